@@ hdl/vmt_pkg.sv @@
// Shared types and constants for the vertex matrix transform core.
`default_nettype none
package vmt_pkg;
   localparam logic [1:0] KIND_POINT  = 2'd0;
   localparam logic [1:0] KIND_COORD  = 2'd1;
   localparam logic [1:0] KIND_NORMAL = 2'd2;
   localparam logic [1:0] KIND_FULL   = 2'd3;
   localparam int NUM_REGS = 8;
   localparam int REG_W = 64;
   localparam int IDX_W = 3;
   localparam int COMP_W = 32;
   localparam int QUO_W = 64;
   localparam logic signed [31:0] S32_MAX = 32'sh7fffffff;
   localparam logic signed [31:0] S32_MIN = 32'sh80000000;

   typedef struct packed {
      logic       valid;
      logic [1:0] kind;
      logic       err;
   } ctl_type;
endpackage
`default_nettype wire

@@ hdl/vmt_lane.sv @@
// One column lane: four products, summed, shifted down and saturated.
`default_nettype none
module vmt_lane import vmt_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  wire                      clock,
   input  wire signed [COMP_W-1:0]  vec [4],
   input  wire signed [COMP_W-1:0]  col [4],
   output logic signed [COMP_W-1:0] sat_out,
   output logic                     sat_err
);
   logic signed [63:0] prod_ff [4];
   logic signed [63:0] prod_in [4];
   logic signed [65:0] sum_ff, sum_in;
   logic signed [65:0] shifted;

   always_comb begin
      for (int k = 0; k < 4; k++) prod_in[k] = vec[k] * col[k];
      sum_in = 66'(prod_ff[0]) + 66'(prod_ff[1]) + 66'(prod_ff[2]) + 66'(prod_ff[3]);
      shifted = sum_ff >>> FRAC_BITS;
      sat_err = 1'b0;
      sat_out = shifted[COMP_W-1:0];
      if (shifted > 66'(S32_MAX)) begin
         sat_out = S32_MAX; sat_err = 1'b1;
      end else if (shifted < 66'(S32_MIN)) begin
         sat_out = S32_MIN; sat_err = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      sum_ff  <= sum_in;
   end
endmodule
`default_nettype wire

@@ hdl/vmt_div_step.sv @@
// One restoring-division stage: one quotient bit per stage, payload carried along.
`default_nettype none
module vmt_div_step import vmt_pkg::*; (
   input  wire               clock,
   input  wire  [QUO_W-1:0]  num_in,
   input  wire  [31:0]       den_in,
   input  wire  [32:0]       rem_in,
   input  wire  [QUO_W-1:0]  quo_in,
   output logic [QUO_W-1:0]  num_out,
   output logic [31:0]       den_out,
   output logic [32:0]       rem_out,
   output logic [QUO_W-1:0]  quo_out
);
   logic [33:0] trial;
   logic [33:0] diff;
   always_comb begin
      trial = {rem_in, num_in[QUO_W-1]};
      diff  = trial - {2'b0, den_in};
   end
   always_ff @(posedge clock) begin
      num_out <= num_in << 1;
      den_out <= den_in;
      if (!diff[33]) begin
         rem_out <= diff[32:0];
         quo_out <= {quo_in[QUO_W-2:0], 1'b1};
      end else begin
         rem_out <= trial[32:0];
         quo_out <= {quo_in[QUO_W-2:0], 1'b0};
      end
   end
endmodule
`default_nettype wire

@@ hdl/vertex_matrix_transform_core.sv @@
// Top level: config matrix, four column lanes, pipelined divide and merge stage.
//
// Usage: pulse start with kind and in_x..in_w while busy is low; busy is
// always low, so one vertex is taken every clock. Each transaction returns
// one result on rsp_* marked by rsp_valid for one cycle. From the accepting
// edge, a transaction passes the product and sum registers of the multiply-add
// lanes (saturation is combinational behind them), 64 stages of the
// restoring divider (one quotient bit per stage, three divider columns side
// by side) and one output register. Kinds that need no divide ride the
// same delay line so results keep order.
// Throughput is one transaction per clock, set by the fully pipelined
// lanes and divider. The receiver cannot stall; results are not held.
// Matrix writes via csr_* apply to transactions accepted afterwards; write
// only while idle. Reset loads the identity matrix and clears the valid
// pipeline; no result appears until a new transaction is accepted.
`default_nettype none
module vertex_matrix_transform_core import vmt_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      start,
   output logic                     busy,
   input  wire  [1:0]               req_kind,
   input  wire  signed [COMP_W-1:0] req_in_x,
   input  wire  signed [COMP_W-1:0] req_in_y,
   input  wire  signed [COMP_W-1:0] req_in_z,
   input  wire  signed [COMP_W-1:0] req_in_w,
   input  wire                      csr_we,
   input  wire  [IDX_W-1:0]         csr_index,
   input  wire  [REG_W-1:0]         csr_wdata,
   output logic                     rsp_valid,
   output logic signed [COMP_W-1:0] rsp_out_x,
   output logic signed [COMP_W-1:0] rsp_out_y,
   output logic signed [COMP_W-1:0] rsp_out_z,
   output logic signed [COMP_W-1:0] rsp_out_w,
   output logic                     rsp_range_error
);
   localparam logic [REG_W-1:0] ONE = REG_W'(1) << FRAC_BITS;
   localparam int MUL_LAT = 2;
   localparam int NSTG = QUO_W;

   logic [REG_W-1:0] regs_ff [NUM_REGS];
   logic signed [COMP_W-1:0] vec_ff [4];
   logic signed [COMP_W-1:0] col [4][4];
   logic signed [COMP_W-1:0] sat [4];
   logic sat_err [4];
   ctl_type ctl_ff [MUL_LAT];
   logic [1:0] kind_ff;
   logic go_ff;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++) regs_ff[i] <= '0;
         regs_ff[0] <= ONE;
         regs_ff[2] <= ONE << 32;
         regs_ff[5] <= ONE;
         regs_ff[7] <= ONE << 32;
      end else if (csr_we) begin
         regs_ff[csr_index] <= csr_wdata;
      end
   end

   always_comb begin
      for (int r = 0; r < 4; r++)
         for (int c = 0; c < 4; c++)
            col[c][r] = (c[0]) ? regs_ff[r*2 + c/2][63:32] : regs_ff[r*2 + c/2][31:0];
   end

   // Capture the vector; w' depends on kind.
   always_ff @(posedge clock) begin
      go_ff   <= reset ? 1'b0 : (start && !busy);
      kind_ff <= req_kind;
      vec_ff[0] <= req_in_x;
      vec_ff[1] <= req_in_y;
      vec_ff[2] <= req_in_z;
      case (req_kind)
         KIND_FULL:   vec_ff[3] <= req_in_w;
         KIND_NORMAL: vec_ff[3] <= '0;
         default:     vec_ff[3] <= COMP_W'(ONE);
      endcase
   end

   for (genvar c = 0; c < 4; c++) begin : g_lane
      vmt_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
         .clock(clock), .vec(vec_ff), .col(col[c]),
         .sat_out(sat[c]), .sat_err(sat_err[c]));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MUL_LAT; i++) ctl_ff[i].valid <= 1'b0;
      end else begin
         ctl_ff[0].valid <= go_ff;
         for (int i = 1; i < MUL_LAT; i++) ctl_ff[i].valid <= ctl_ff[i-1].valid;
      end
      ctl_ff[0].kind <= kind_ff;
      ctl_ff[0].err  <= 1'b0;
      for (int i = 1; i < MUL_LAT; i++) begin
         ctl_ff[i].kind <= ctl_ff[i-1].kind;
         ctl_ff[i].err  <= ctl_ff[i-1].err;
      end
   end

   // Merge lane flags and set up divider operands (magnitudes).
   ctl_type mctl;
   logic signed [COMP_W-1:0] wv;
   logic [31:0] den_mag;
   logic [QUO_W-1:0] num_mag [3];
   logic neg [3];
   always_comb begin
      mctl = ctl_ff[MUL_LAT-1];
      mctl.err = sat_err[0] | sat_err[1] | sat_err[2] |
                 (sat_err[3] && mctl.kind != KIND_NORMAL);
      wv = sat[3];
      den_mag = wv[31] ? 32'(-33'(wv)) : 32'(wv);
      for (int c = 0; c < 3; c++) begin
         neg[c] = sat[c][31] ^ wv[31];
         num_mag[c] = (sat[c][31] ? QUO_W'(-65'(sat[c])) : QUO_W'(sat[c])) << FRAC_BITS;
      end
   end

   logic [QUO_W-1:0] dn [3][NSTG+1];
   logic [31:0]      dd [3][NSTG+1];
   logic [32:0]      dr [3][NSTG+1];
   logic [QUO_W-1:0] dq [3][NSTG+1];
   ctl_type dctl_ff [1:NSTG];
   logic signed [COMP_W-1:0] raw_ff [1:NSTG][4];
   logic negq_ff [1:NSTG][3];

   for (genvar c = 0; c < 3; c++) begin : g_div
      assign dn[c][0] = num_mag[c];
      assign dd[c][0] = den_mag;
      assign dr[c][0] = '0;
      assign dq[c][0] = '0;
      for (genvar s = 0; s < NSTG; s++) begin : g_stg
         vmt_div_step u_step (
            .clock(clock), .num_in(dn[c][s]), .den_in(dd[c][s]), .rem_in(dr[c][s]),
            .quo_in(dq[c][s]), .num_out(dn[c][s+1]), .den_out(dd[c][s+1]),
            .rem_out(dr[c][s+1]), .quo_out(dq[c][s+1]));
      end
   end

   always_ff @(posedge clock) begin
      dctl_ff[1].kind <= mctl.kind;
      dctl_ff[1].err  <= mctl.err;
      raw_ff[1]  <= sat;
      negq_ff[1] <= neg;
      for (int s = 2; s <= NSTG; s++) begin
         dctl_ff[s].kind <= dctl_ff[s-1].kind;
         dctl_ff[s].err  <= dctl_ff[s-1].err;
         raw_ff[s] <= raw_ff[s-1];
         negq_ff[s] <= negq_ff[s-1];
      end
      if (reset) begin
         for (int s = 1; s <= NSTG; s++) dctl_ff[s].valid <= 1'b0;
      end else begin
         dctl_ff[1].valid <= mctl.valid;
         for (int s = 2; s <= NSTG; s++) dctl_ff[s].valid <= dctl_ff[s-1].valid;
      end
   end

   // Final merge: apply divide result or pass through, then register.
   ctl_type fctl;
   logic signed [COMP_W-1:0] res_in [4];
   logic err_in;
   logic [QUO_W-1:0] q;
   logic signed [COMP_W-1:0] nv;
   always_comb begin
      fctl = dctl_ff[NSTG];
      err_in = fctl.err;
      q  = '0;
      nv = '0;
      for (int c = 0; c < 4; c++) res_in[c] = raw_ff[NSTG][c];
      if (fctl.kind == KIND_COORD) begin
         for (int c = 0; c < 3; c++) begin
            q  = dq[c][NSTG];
            nv = raw_ff[NSTG][c];
            if (raw_ff[NSTG][3] == '0) begin
               err_in = 1'b1;
               res_in[c] = (nv > 0) ? S32_MAX : ((nv < 0) ? S32_MIN : '0);
            end else if (!negq_ff[NSTG][c]) begin
               if (q > QUO_W'(S32_MAX)) begin
                  res_in[c] = S32_MAX; err_in = 1'b1;
               end else res_in[c] = q[31:0];
            end else begin
               if (q > QUO_W'(33'h080000000)) begin
                  res_in[c] = S32_MIN; err_in = 1'b1;
               end else res_in[c] = 32'(-q[32:0]);
            end
         end
      end
      if (fctl.kind == KIND_COORD || fctl.kind == KIND_NORMAL) res_in[3] = '0;
   end

   always_ff @(posedge clock) begin
      rsp_valid <= reset ? 1'b0 : fctl.valid;
      rsp_out_x <= res_in[0];
      rsp_out_y <= res_in[1];
      rsp_out_z <= res_in[2];
      rsp_out_w <= res_in[3];
      rsp_range_error <= err_in;
   end

   a_norm_w: assert property (@(posedge clock) disable iff (reset)
      fctl.valid && fctl.kind == KIND_NORMAL |=> rsp_out_w == '0)
      else $error("normal result has nonzero w");
   a_coord_w: assert property (@(posedge clock) disable iff (reset)
      fctl.valid && fctl.kind == KIND_COORD |=> rsp_out_w == '0)
      else $error("coordinate result has nonzero w");
   a_zero_div: assert property (@(posedge clock) disable iff (reset)
      fctl.valid && fctl.kind == KIND_COORD && raw_ff[NSTG][3] == '0 |=> rsp_range_error)
      else $error("zero divisor did not flag");
endmodule
`default_nettype wire

@@ dv/testbench.sv @@
// Self-checking testbench for the vertex matrix transform core.
`timescale 1ns / 100ps
`default_nettype none
module testbench import vmt_pkg::*; ();

   localparam int FRAC = 16;
   localparam int LATENCY = 68;
   localparam longint LIMIT = 400000;
   localparam logic [63:0] ONE = 64'd1 << FRAC;

   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
      logic signed [31:0] w;
      logic               err;
   } vertex_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [1:0] req_kind = '0;
   logic signed [31:0] req_in_x = '0, req_in_y = '0, req_in_z = '0, req_in_w = '0;
   logic csr_we = 1'b0;
   logic [IDX_W-1:0] csr_index = '0;
   logic [REG_W-1:0] csr_wdata = '0;
   logic rsp_valid;
   logic signed [31:0] rsp_out_x, rsp_out_y, rsp_out_z, rsp_out_w;
   logic rsp_range_error;

   logic [63:0] matrix_regs [NUM_REGS];
   vertex_result_type expected_vertices[$];
   int mismatches = 0;
   longint cycles = 0;
   bit idle_enable = 1'b1;

   vertex_matrix_transform_core #(.FRAC_BITS(FRAC)) u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_kind(req_kind), .req_in_x(req_in_x), .req_in_y(req_in_y),
      .req_in_z(req_in_z), .req_in_w(req_in_w), .csr_we(csr_we),
      .csr_index(csr_index), .csr_wdata(csr_wdata), .rsp_valid(rsp_valid),
      .rsp_out_x(rsp_out_x), .rsp_out_y(rsp_out_y), .rsp_out_z(rsp_out_z),
      .rsp_out_w(rsp_out_w), .rsp_range_error(rsp_range_error)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   function automatic logic signed [31:0] entry_at(int r, int c);
      logic [63:0] reg_val;
      reg_val = matrix_regs[r * 2 + c / 2];
      return (c % 2 == 1) ? reg_val[63:32] : reg_val[31:0];
   endfunction

   function automatic logic signed [31:0] saturate(logic signed [127:0] v, ref bit err);
      if (v > 128'sd2147483647) begin
         err = 1'b1;
         return S32_MAX;
      end
      if (v < -128'sd2147483648) begin
         err = 1'b1;
         return S32_MIN;
      end
      return v[31:0];
   endfunction

   function automatic vertex_result_type transform_vertex(logic [1:0] kind,
         logic signed [31:0] x, logic signed [31:0] y,
         logic signed [31:0] z, logic signed [31:0] w);
      logic signed [127:0] vec [4];
      logic signed [127:0] acc;
      logic signed [127:0] num, quo;
      logic signed [31:0] col [4];
      bit err, dummy;
      vertex_result_type res;
      err = 1'b0;
      dummy = 1'b0;
      vec[0] = x;
      vec[1] = y;
      vec[2] = z;
      vec[3] = (kind == KIND_FULL) ? 128'(w) : (kind == KIND_NORMAL) ? 128'sd0
               : 128'(signed'(ONE));
      for (int c = 0; c < 4; c++) begin
         acc = 0;
         for (int k = 0; k < 4; k++) acc += vec[k] * 128'(entry_at(k, c));
         acc = acc >>> FRAC;
         if (c == 3 && kind == KIND_NORMAL) col[c] = saturate(acc, dummy);
         else col[c] = saturate(acc, err);
      end
      if (kind == KIND_COORD) begin
         for (int c = 0; c < 3; c++) begin
            num = 128'(col[c]) <<< FRAC;
            if (col[3] == 0) begin
               err = 1'b1;
               col[c] = (col[c] > 0) ? S32_MAX : (col[c] < 0) ? S32_MIN : 32'sd0;
            end else begin
               quo = num / 128'(col[3]);
               col[c] = saturate(quo, err);
            end
         end
      end
      if (kind == KIND_COORD || kind == KIND_NORMAL) col[3] = 0;
      res.x = col[0];
      res.y = col[1];
      res.z = col[2];
      res.w = col[3];
      res.err = err;
      return res;
   endfunction

   // Results are checked at the edge that ends their strobe cycle.
   always @(posedge clock) begin
      vertex_result_type exp_v;
      if (!reset && rsp_valid) begin
         if (expected_vertices.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("Unexpected result at cycle %0d", cycles);
         end else begin
            exp_v = expected_vertices.pop_front();
            if (exp_v.x !== rsp_out_x || exp_v.y !== rsp_out_y || exp_v.z !== rsp_out_z ||
                exp_v.w !== rsp_out_w || exp_v.err !== rsp_range_error) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("Mismatch: exp %h %h %h %h e%b got %h %h %h %h e%b",
                     exp_v.x, exp_v.y, exp_v.z, exp_v.w, exp_v.err, rsp_out_x,
                     rsp_out_y, rsp_out_z, rsp_out_w, rsp_range_error);
            end
         end
      end
   end

   task automatic idle_cycles();
      int gap;
      gap = $urandom_range(1, 7);
      repeat (gap) @(posedge clock);
   endtask

   task automatic send_vertex(logic [1:0] kind, logic [31:0] x, logic [31:0] y,
         logic [31:0] z, logic [31:0] w);
      start <= 1'b1;
      req_kind <= kind;
      req_in_x <= x;
      req_in_y <= y;
      req_in_z <= z;
      req_in_w <= w;
      @(posedge clock);
      while (busy) @(posedge clock);
      expected_vertices.push_back(transform_vertex(kind, x, y, z, w));
      if (idle_enable && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         idle_cycles();
      end
   endtask

   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (expected_vertices.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic write_reg(int idx, logic [63:0] value);
      csr_we <= 1'b1;
      csr_index <= IDX_W'(idx);
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      matrix_regs[idx] = value;
      @(posedge clock);
   endtask

   function automatic logic [31:0] random_component();
      case ($urandom_range(0, 5))
         0: return $urandom();
         1: return 32'($urandom_range(0, 8)) << FRAC;
         2: return -(32'($urandom_range(0, 8)) << FRAC);
         3: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
         default: return 32'(signed'($urandom_range(0, 1 << 20)) - (1 << 19));
      endcase
   endfunction

   function automatic logic [63:0] random_matrix_reg(int mode);
      logic [31:0] lo, hi;
      if (mode == 0) begin
         lo = $urandom();
         hi = $urandom();
      end else begin
         lo = 32'(signed'($urandom_range(0, 4 << FRAC)) - (2 << FRAC));
         hi = 32'(signed'($urandom_range(0, 4 << FRAC)) - (2 << FRAC));
      end
      return {hi, lo};
   endfunction

   task automatic test_identity_directed();
      logic [31:0] edges [6] = '{32'h0, 32'h7fffffff, 32'h80000000, 32'hffffffff,
                                 32'h00010000, 32'hffff0000};
      for (int k = 0; k < 4; k++) begin
         send_vertex(k[1:0], 32'h0001_8000, 32'hfffe_0000, 32'h0003_0000, 32'h0002_0000);
         send_vertex(k[1:0], edges[1], edges[2], edges[3], edges[$urandom_range(0, 5)]);
      end
      // full kind, w zero (no divide); zero divisor: coordinate with zero w column
      send_vertex(KIND_FULL, edges[1], edges[2], 0, 0);
      drain();
      write_reg(7, 64'd0);
      send_vertex(KIND_COORD, 32'h0001_0000, 32'hffff_0000, 0, 0);
      drain();
      write_reg(7, 64'h0000_0000_0000_0000 | (64'h8000_0000 << 32));
      send_vertex(KIND_COORD, 32'h0001_0000, 32'hffff_0000, 32'h0002_0000, 0);
      send_vertex(KIND_FULL, edges[1], edges[1], edges[1], edges[1]);
      drain();
   endtask

   task automatic test_register_extremes();
      logic [63:0] extremes [3] = '{64'hffff_ffff_ffff_ffff, 64'h7fff_ffff_8000_0000, 64'd0};
      foreach (extremes[e]) begin
         for (int r = 0; r < NUM_REGS; r++) write_reg(r, extremes[e]);
         for (int k = 0; k < 4; k++)
            send_vertex(k[1:0], 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000);
         drain();
      end
   endtask

   task automatic test_random_matrices();
      for (int phase = 0; phase < 10; phase++) begin
         for (int r = 0; r < NUM_REGS; r++) write_reg(r, random_matrix_reg(phase % 3 == 0));
         if (phase >= 8) idle_enable = 1'b0;
         for (int n = 0; n < 50; n++)
            send_vertex(2'($urandom_range(0, 3)), random_component(), random_component(),
               random_component(), random_component());
         drain();
      end
   endtask

   initial begin
      matrix_regs[0] = ONE;
      matrix_regs[1] = 0;
      matrix_regs[2] = ONE << 32;
      matrix_regs[3] = 0;
      matrix_regs[4] = 0;
      matrix_regs[5] = ONE;
      matrix_regs[6] = 0;
      matrix_regs[7] = ONE << 32;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_identity_directed();
      test_register_extremes();
      test_random_matrices();
      if (mismatches == 0 && expected_vertices.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end
endmodule
`default_nettype wire

@@ vertex_matrix_transform_core.f @@
hdl/vmt_pkg.sv
hdl/vmt_lane.sv
hdl/vmt_div_step.sv
hdl/vertex_matrix_transform_core.sv
dv/testbench.sv
